// File: design/scp_pkg.sv
package scp_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned THRESH_W   = 16;
  localparam int unsigned MIN_W      = 10;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned IVL_W      = 10;

  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned COUNT_WIDTH_DEF  = 10;

  localparam logic [THRESH_W-1:0] MOVE_THRESHOLD_RST = THRESH_W'(512);
  localparam logic [MIN_W-1:0]    MIN_SAMPLES_RST    = MIN_W'(50);
  localparam logic [MS_W-1:0]     READY_MS_RST       = MS_W'(3000);
  localparam logic [MS_W-1:0]     TOTAL_MS_RST       = MS_W'(8000);
  localparam logic [MS_W-1:0]     TIMEOUT_MS_RST     = MS_W'(10000);
  localparam logic [IVL_W-1:0]    SAMPLE_IVL_RST     = IVL_W'(50);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOVE_THRESHOLD = 3'd0,
    CFG_MIN_SAMPLES    = 3'd1,
    CFG_READY_MS       = 3'd2,
    CFG_TOTAL_MS       = 3'd3,
    CFG_TIMEOUT_MS     = 3'd4,
    CFG_SAMPLE_IVL     = 3'd5
  } cfg_idx_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 2'd0,
    REQ_START  = 2'd1,
    REQ_CANCEL = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_IDLE      = 3'd0,
    ST_GET_READY = 3'd1,
    ST_SAMPLING  = 3'd2,
    ST_DONE      = 3'd3,
    ST_MOVED     = 3'd4,
    ST_TIMEOUT   = 3'd5,
    ST_CANCELLED = 3'd6
  } status_e;

endpackage

// File: design/stillness_calibration_sequencer.sv
// Stillness calibration sequencer.
// Input channel (in_valid_i / in_stall_o) carries one request per transaction:
// a tick with a Y/Z sample, a start or a cancel, stamped with a millisecond time.
// Every request yields exactly one result transaction on out_valid_o / out_stall_i
// with the run status, the sample count, the elapsed time and, on a successful
// finish, the truncated Y/Z averages.
// The two 32-bit time differences are formed bit-serially, and the averages of a run
// that finishes with samples come out of one shared bit-serial divider, one quotient
// bit per cycle. One request is in flight at a time: a new request is not taken until
// the result of the last one has been moved to the output register.
// A new request is taken while a finished result still waits in the output register.
// If the receiver stalls, the result is held; the next result waits behind it.
// Reset clears the run state and loads the register defaults. Configuration writes
// (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at once; they are to be made while
// idle, which binds the user, since the block itself does not enforce it.
module stillness_calibration_sequencer import scp_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [REQ_W-1:0]        req_type_i,
  input  logic [TIME_W-1:0]       now_ms_i,
  input  logic [SAMPLE_WIDTH-1:0] accel_y_i,
  input  logic [SAMPLE_WIDTH-1:0] accel_z_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [STATUS_W-1:0]     status_o,
  output logic [SAMPLE_WIDTH-1:0] origin_y_o,
  output logic [SAMPLE_WIDTH-1:0] origin_z_o,
  output logic [COUNT_WIDTH-1:0]  samples_taken_o,
  output logic [TIME_W-1:0]       elapsed_ms_o
);

  localparam int unsigned SUM_W   = SAMPLE_WIDTH + COUNT_WIDTH + 1;
  localparam int unsigned MOVE_W  = (SAMPLE_WIDTH + 2 > THRESH_W) ? SAMPLE_WIDTH + 2 : THRESH_W;
  localparam int unsigned CMIN_W  = (COUNT_WIDTH > MIN_W) ? COUNT_WIDTH : MIN_W;
  localparam int unsigned BIT_W   = $clog2(TIME_W);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(TIME_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUB,
    S_EVAL,
    S_DIV,
    S_EMIT
  } state_e;

  // configuration
  logic [THRESH_W-1:0] move_threshold_q;
  logic [MIN_W-1:0]    min_samples_q;
  logic [MS_W-1:0]     ready_ms_q;
  logic [MS_W-1:0]     total_ms_q;
  logic [MS_W-1:0]     timeout_ms_q;
  logic [IVL_W-1:0]    sample_ivl_q;

  // control and run state
  state_e                  state_q;
  logic [BIT_W-1:0]        bit_q;
  logic                    running_q;
  logic [TIME_W-1:0]       start_q;
  logic [TIME_W-1:0]       last_q;
  logic [SAMPLE_WIDTH-1:0] prev_y_q, prev_z_q;
  logic [SUM_W-1:0]        sum_y_q, sum_z_q;
  logic [COUNT_WIDTH-1:0]  count_q;
  logic                    div_start_q;
  logic                    div_sel_q;
  status_e                 res_status_q;
  logic [SAMPLE_WIDTH-1:0] res_oy_q, res_oz_q;
  logic [TIME_W-1:0]       res_el_q;
  logic                    out_valid_q;
  logic [STATUS_W-1:0]     out_status_q;
  logic [SAMPLE_WIDTH-1:0] out_oy_q, out_oz_q;
  logic [COUNT_WIDTH-1:0]  out_cnt_q;
  logic [TIME_W-1:0]       out_el_q;

  // captured transaction and serial datapath
  logic [REQ_W-1:0]        req_q;
  logic [TIME_W-1:0]       now_q;
  logic [SAMPLE_WIDTH-1:0] y_q, z_q;
  logic [TIME_W-1:0]       el_q, gap_q;
  logic                    bw_el_q, bw_gap_q;
  logic [MOVE_W-1:0]       move_q;

  logic                    in_acc;
  logic                    el_bit, gap_bit, bw_el_d, bw_gap_d;
  logic [SAMPLE_WIDTH:0]   dy, dz, ady, adz;
  logic [MOVE_W-1:0]       move_d;
  logic                    gap_ok, moved, cnt_full, past_timeout, in_ready, past_total;
  logic [COUNT_WIDTH-1:0]  cnt_new;
  logic                    enough;
  status_e                 phase;
  logic [SUM_W-1:0]        y_ext, z_ext;
  logic                    div_done;
  logic [SAMPLE_WIDTH-1:0] div_quo;

  assign in_acc = (state_q == S_IDLE) && in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_threshold_q <= MOVE_THRESHOLD_RST;
      min_samples_q    <= MIN_SAMPLES_RST;
      ready_ms_q       <= READY_MS_RST;
      total_ms_q       <= TOTAL_MS_RST;
      timeout_ms_q     <= TIMEOUT_MS_RST;
      sample_ivl_q     <= SAMPLE_IVL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MOVE_THRESHOLD: move_threshold_q <= cfg_wdata_i[THRESH_W-1:0];
        CFG_MIN_SAMPLES:    min_samples_q    <= cfg_wdata_i[MIN_W-1:0];
        CFG_READY_MS:       ready_ms_q       <= cfg_wdata_i[MS_W-1:0];
        CFG_TOTAL_MS:       total_ms_q       <= cfg_wdata_i[MS_W-1:0];
        CFG_TIMEOUT_MS:     timeout_ms_q     <= cfg_wdata_i[MS_W-1:0];
        CFG_SAMPLE_IVL:     sample_ivl_q     <= cfg_wdata_i[IVL_W-1:0];
        default: ;
      endcase
    end
  end

  // lsb-first serial subtractors: now - start_time and now - last_sample_time
  assign el_bit   = now_q[0] ^ start_q[0] ^ bw_el_q;
  assign bw_el_d  = (~now_q[0] & start_q[0]) | (~(now_q[0] ^ start_q[0]) & bw_el_q);
  assign gap_bit  = now_q[0] ^ last_q[0] ^ bw_gap_q;
  assign bw_gap_d = (~now_q[0] & last_q[0]) | (~(now_q[0] ^ last_q[0]) & bw_gap_q);

  assign dy     = {y_q[SAMPLE_WIDTH-1], y_q} - {prev_y_q[SAMPLE_WIDTH-1], prev_y_q};
  assign dz     = {z_q[SAMPLE_WIDTH-1], z_q} - {prev_z_q[SAMPLE_WIDTH-1], prev_z_q};
  assign ady    = dy[SAMPLE_WIDTH] ? (~dy + (SAMPLE_WIDTH+1)'(1)) : dy;
  assign adz    = dz[SAMPLE_WIDTH] ? (~dz + (SAMPLE_WIDTH+1)'(1)) : dz;
  assign move_d = MOVE_W'(ady) + MOVE_W'(adz);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q    <= req_type_i;
      now_q    <= now_ms_i;
      y_q      <= accel_y_i;
      z_q      <= accel_z_i;
      bw_el_q  <= 1'b0;
      bw_gap_q <= 1'b0;
    end else if (state_q == S_SUB) begin
      now_q    <= {now_q[0], now_q[TIME_W-1:1]};
      el_q     <= {el_bit, el_q[TIME_W-1:1]};
      gap_q    <= {gap_bit, gap_q[TIME_W-1:1]};
      bw_el_q  <= bw_el_d;
      bw_gap_q <= bw_gap_d;
      move_q   <= move_d;
    end
  end

  // decision terms, all from registered values
  assign gap_ok       = gap_q >= TIME_W'(sample_ivl_q);
  assign moved        = move_q > MOVE_W'(move_threshold_q);
  assign cnt_full     = &count_q;
  assign past_timeout = el_q > TIME_W'(timeout_ms_q);
  assign in_ready     = el_q < TIME_W'(ready_ms_q);
  assign past_total   = el_q > TIME_W'(total_ms_q);
  assign cnt_new      = count_q + COUNT_WIDTH'(gap_ok && !cnt_full);
  assign enough       = CMIN_W'(cnt_new) >= CMIN_W'(min_samples_q);
  assign y_ext        = {{(SUM_W-SAMPLE_WIDTH){y_q[SAMPLE_WIDTH-1]}}, y_q};
  assign z_ext        = {{(SUM_W-SAMPLE_WIDTH){z_q[SAMPLE_WIDTH-1]}}, z_q};

  always_comb begin
    if (!running_q) begin
      phase = ST_IDLE;
    end else if (in_ready) begin
      phase = ST_GET_READY;
    end else begin
      phase = ST_SAMPLING;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      bit_q        <= '0;
      running_q    <= 1'b0;
      start_q      <= '0;
      last_q       <= '0;
      prev_y_q     <= '0;
      prev_z_q     <= '0;
      sum_y_q      <= '0;
      sum_z_q      <= '0;
      count_q      <= '0;
      div_start_q  <= 1'b0;
      div_sel_q    <= 1'b0;
      res_status_q <= ST_IDLE;
      res_oy_q     <= '0;
      res_oz_q     <= '0;
      res_el_q     <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_oy_q     <= '0;
      out_oz_q     <= '0;
      out_cnt_q    <= '0;
      out_el_q     <= '0;
    end else begin
      div_start_q <= 1'b0;
      if (out_valid_q && !out_stall_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_SUB;
            bit_q   <= '0;
          end
        end
        S_SUB: begin
          // time stores rotate once around and come back intact
          start_q <= {start_q[0], start_q[TIME_W-1:1]};
          last_q  <= {last_q[0], last_q[TIME_W-1:1]};
          bit_q   <= bit_q + BIT_W'(1);
          if (bit_q == BIT_LAST) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          state_q  <= S_EMIT;
          res_oy_q <= '0;
          res_oz_q <= '0;
          res_el_q <= running_q ? el_q : '0;
          if (req_q == REQ_START && !running_q) begin
            running_q    <= 1'b1;
            start_q      <= now_q;
            prev_y_q     <= y_q;
            prev_z_q     <= z_q;
            sum_y_q      <= '0;
            sum_z_q      <= '0;
            count_q      <= '0;
            res_el_q     <= '0;
            res_status_q <= (ready_ms_q != '0) ? ST_GET_READY : ST_SAMPLING;
          end else if (req_q == REQ_CANCEL) begin
            running_q    <= 1'b0;
            res_el_q     <= '0;
            res_status_q <= running_q ? ST_CANCELLED : ST_IDLE;
          end else if (req_q != REQ_TICK || !running_q) begin
            res_status_q <= phase;
          end else if (past_timeout) begin
            running_q    <= 1'b0;
            res_status_q <= ST_TIMEOUT;
          end else if (in_ready) begin
            prev_y_q     <= y_q;
            prev_z_q     <= z_q;
            sum_y_q      <= '0;
            sum_z_q      <= '0;
            count_q      <= '0;
            res_status_q <= ST_GET_READY;
          end else begin
            if (gap_ok) begin
              last_q   <= now_q;
              prev_y_q <= y_q;
              prev_z_q <= z_q;
            end
            if (gap_ok && moved) begin
              running_q    <= 1'b0;
              res_status_q <= ST_MOVED;
            end else begin
              if (gap_ok && !cnt_full) begin
                sum_y_q <= sum_y_q + y_ext;
                sum_z_q <= sum_z_q + z_ext;
                count_q <= cnt_new;
              end
              if (past_total && enough) begin
                running_q    <= 1'b0;
                res_status_q <= ST_DONE;
                // no samples: both averages stay zero
                if (cnt_new != '0) begin
                  state_q     <= S_DIV;
                  div_start_q <= 1'b1;
                  div_sel_q   <= 1'b0;
                end
              end else begin
                res_status_q <= ST_SAMPLING;
              end
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (!div_sel_q) begin
              res_oy_q    <= div_quo;
              div_sel_q   <= 1'b1;
              div_start_q <= 1'b1;
            end else begin
              res_oz_q <= div_quo;
              state_q  <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_oy_q     <= res_oy_q;
            out_oz_q     <= res_oz_q;
            out_cnt_q    <= count_q;
            out_el_q     <= res_el_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  scp_div #(
    .DIVIDEND_W(SUM_W),
    .DIVISOR_W (COUNT_WIDTH),
    .QUO_W     (SAMPLE_WIDTH)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start_q),
    .dividend_i(div_sel_q ? sum_z_q : sum_y_q),
    .divisor_i (count_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  assign in_stall_o      = state_q != S_IDLE;
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign origin_y_o      = out_oy_q;
  assign origin_z_o      = out_oz_q;
  assign samples_taken_o = out_cnt_q;
  assign elapsed_ms_o    = out_el_q;

endmodule

// File: design/scp_div.sv
module scp_div import scp_pkg::*; #(
  parameter int unsigned DIVIDEND_W = SAMPLE_WIDTH_DEF + COUNT_WIDTH_DEF + 1,
  parameter int unsigned DIVISOR_W  = COUNT_WIDTH_DEF,
  parameter int unsigned QUO_W      = SAMPLE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [QUO_W-1:0]      quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  neg_q;
  logic [DIVIDEND_W-1:0] mag_q;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W:0]    trial;
  logic                  ge;
  logic [DIVIDEND_W-1:0] quo_signed;

  // one quotient bit per cycle, restoring, on the magnitude
  assign trial = {rem_q, mag_q[DIVIDEND_W-1]};
  assign ge    = trial >= {1'b0, divisor_i};

  always_comb begin
    if (ge) begin
      rem_d = DIVISOR_W'(trial - {1'b0, divisor_i});
    end else begin
      rem_d = DIVISOR_W'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DIVIDEND_W-1];
      mag_q <= dividend_i[DIVIDEND_W-1] ? (~dividend_i + DIVIDEND_W'(1)) : dividend_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[DIVIDEND_W-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
    end
  end

  // truncation toward zero: divide the magnitude, then restore the sign
  assign quo_signed = neg_q ? (~quo_q + DIVIDEND_W'(1)) : quo_q;
  assign quotient_o = quo_signed[QUO_W-1:0];
  assign done_o     = done_q;

endmodule

// File: design/scp_checker.sv
module scp_checker import scp_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [STATUS_W-1:0]     status_o,
  input logic [SAMPLE_WIDTH-1:0] origin_y_o,
  input logic [SAMPLE_WIDTH-1:0] origin_z_o,
  input logic [COUNT_WIDTH-1:0]  samples_taken_o,
  input logic [TIME_W-1:0]       elapsed_ms_o
);

  // a held result keeps every field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(origin_y_o) && $stable(origin_z_o) && $stable(samples_taken_o) &&
      $stable(elapsed_ms_o))
    else $error("stalled result changed");

  // one request in flight: busy right after a transaction is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a request is in flight");

  // averages only on a successful finish
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_DONE |-> origin_y_o == '0 && origin_z_o == '0)
    else $error("averages reported without a finished run");

  // no elapsed time outside a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_IDLE || status_o == ST_CANCELLED) |->
      elapsed_ms_o == '0)
    else $error("elapsed time reported while not calibrating");

endmodule

bind stillness_calibration_sequencer scp_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH),
  .COUNT_WIDTH (COUNT_WIDTH)
) u_scp_checker (.*);

// File: dv/stillness_calibration_sequencer_tb.sv
`timescale 1ns / 1ps

module stillness_calibration_sequencer_tb;
  import scp_pkg::*;

  localparam int unsigned SW = SAMPLE_WIDTH_DEF;
  localparam int unsigned CW = COUNT_WIDTH_DEF;
  localparam int SMAX = 2 ** (SW - 1) - 1;
  localparam int SMIN = -(2 ** (SW - 1));
  localparam logic [CW-1:0] COUNT_SAT = '1;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned DRAIN_CYCLES = 130;

  typedef struct packed {
    status_e           status;
    logic [SW-1:0]     origin_y;
    logic [SW-1:0]     origin_z;
    logic [CW-1:0]     samples;
    logic [TIME_W-1:0] elapsed;
  } calib_report_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [REQ_W-1:0]     req_type = '0;
  logic [TIME_W-1:0]    now_ms = '0;
  logic [SW-1:0]        accel_y = '0;
  logic [SW-1:0]        accel_z = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [SW-1:0]        origin_y;
  logic [SW-1:0]        origin_z;
  logic [CW-1:0]        samples_taken;
  logic [TIME_W-1:0]    elapsed_ms;

  // predictor state and register copies
  logic                     cal_active = 1'b0;
  logic [TIME_W-1:0]        cal_t0 = '0;
  logic [TIME_W-1:0]        smp_t_last = '0;
  logic signed [SW-1:0]     anchor_y = '0;
  logic signed [SW-1:0]     anchor_z = '0;
  longint                   acc_y = 0;
  longint                   acc_z = 0;
  logic [CW-1:0]            n_stable = '0;
  logic [THRESH_W-1:0]      thr_c = MOVE_THRESHOLD_RST;
  logic [MIN_W-1:0]         min_c = MIN_SAMPLES_RST;
  logic [MS_W-1:0]          ready_c = READY_MS_RST;
  logic [MS_W-1:0]          total_c = TOTAL_MS_RST;
  logic [MS_W-1:0]          tmo_c = TIMEOUT_MS_RST;
  logic [IVL_W-1:0]         ivl_c = SAMPLE_IVL_RST;

  calib_report_t calib_reports_q[$];
  int unsigned   items_sent = 0;
  int unsigned   n_mismatch = 0;
  int unsigned   n_done = 0;
  int unsigned   n_moved = 0;
  int unsigned   n_timeout = 0;
  int unsigned   n_cancel = 0;
  int unsigned   n_saturated = 0;
  bit            quiet = 1'b0;

  stillness_calibration_sequencer dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .req_type_i      (req_type),
    .now_ms_i        (now_ms),
    .accel_y_i       (accel_y),
    .accel_z_i       (accel_z),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .origin_y_o      (origin_y),
    .origin_z_o      (origin_z),
    .samples_taken_o (samples_taken),
    .elapsed_ms_o    (elapsed_ms)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [SW-1:0] clamp_sample(int v);
    if (v > SMAX) return SW'(SMAX);
    if (v < SMIN) return SW'(SMIN);
    return SW'(v);
  endfunction

  // mostly short pauses, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 2);
    if (roll < 95) return $urandom_range(3, 8);
    return $urandom_range(15, 50);
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    n_mismatch++;
    if (n_mismatch <= 40) begin
      $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  task automatic step_calibration(logic [REQ_W-1:0] req, logic [TIME_W-1:0] now,
                                  logic signed [SW-1:0] y, logic signed [SW-1:0] z);
    logic [TIME_W-1:0] elapsed;
    calib_report_t     rep;
    int                dy;
    int                dz;
    elapsed = now - cal_t0;
    rep = '0;
    rep.status = ST_IDLE;
    if (req == REQ_START && !cal_active) begin
      cal_active = 1'b1;
      cal_t0 = now;
      anchor_y = y;
      anchor_z = z;
      acc_y = 0;
      acc_z = 0;
      n_stable = '0;
      rep.status = (ready_c != 0) ? ST_GET_READY : ST_SAMPLING;
    end else if (req == REQ_CANCEL) begin
      if (cal_active) begin
        cal_active = 1'b0;
        rep.status = ST_CANCELLED;
        n_cancel++;
      end
    end else if (req != REQ_TICK || !cal_active) begin
      // ignored request: report the phase we are in
      if (cal_active) begin
        rep.status = (elapsed < ready_c) ? ST_GET_READY : ST_SAMPLING;
        rep.elapsed = elapsed;
      end
    end else begin
      rep.elapsed = elapsed;
      if (elapsed > tmo_c) begin
        cal_active = 1'b0;
        rep.status = ST_TIMEOUT;
      end else if (elapsed < ready_c) begin
        anchor_y = y;
        anchor_z = z;
        acc_y = 0;
        acc_z = 0;
        n_stable = '0;
        rep.status = ST_GET_READY;
      end else begin
        rep.status = ST_SAMPLING;
        if (now - smp_t_last >= ivl_c) begin
          dy = int'(y) - int'(anchor_y);
          dz = int'(z) - int'(anchor_z);
          if (dy < 0) dy = -dy;
          if (dz < 0) dz = -dz;
          smp_t_last = now;
          anchor_y = y;
          anchor_z = z;
          if (dy + dz > int'(thr_c)) begin
            cal_active = 1'b0;
            rep.status = ST_MOVED;
          end else if (n_stable != COUNT_SAT) begin
            acc_y += y;
            acc_z += z;
            n_stable++;
          end else begin
            n_saturated++;
          end
        end
        if (rep.status == ST_SAMPLING && elapsed > total_c && n_stable >= min_c) begin
          cal_active = 1'b0;
          rep.status = ST_DONE;
          if (n_stable != 0) begin
            rep.origin_y = SW'(acc_y / longint'(n_stable));
            rep.origin_z = SW'(acc_z / longint'(n_stable));
          end
        end
      end
    end
    rep.samples = n_stable;
    case (rep.status)
      ST_DONE:    n_done++;
      ST_MOVED:   n_moved++;
      ST_TIMEOUT: n_timeout++;
      default: ;
    endcase
    calib_reports_q.push_back(rep);
  endtask

  task automatic send_req(logic [REQ_W-1:0] req, logic [TIME_W-1:0] now,
                          logic [SW-1:0] y, logic [SW-1:0] z);
    int unsigned gap;
    in_valid <= 1'b1;
    req_type <= req;
    now_ms   <= now;
    accel_y  <= y;
    accel_z  <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_calibration(req, now, y, z);
    items_sent++;
    gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off new requests until every pending report is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (calib_reports_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_MOVE_THRESHOLD: thr_c = THRESH_W'(val);
      CFG_MIN_SAMPLES:    min_c = MIN_W'(val);
      CFG_READY_MS:       ready_c = MS_W'(val);
      CFG_TOTAL_MS:       total_c = MS_W'(val);
      CFG_TIMEOUT_MS:     tmo_c = MS_W'(val);
      CFG_SAMPLE_IVL:     ivl_c = IVL_W'(val);
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned thr, int unsigned mn, int unsigned rdy,
                            int unsigned tot, int unsigned tmo, int unsigned ivl);
    write_reg(CFG_MOVE_THRESHOLD, CFG_W'(thr));
    write_reg(CFG_MIN_SAMPLES, CFG_W'(mn));
    write_reg(CFG_READY_MS, CFG_W'(rdy));
    write_reg(CFG_TOTAL_MS, CFG_W'(tot));
    write_reg(CFG_TIMEOUT_MS, CFG_W'(tmo));
    write_reg(CFG_SAMPLE_IVL, CFG_W'(ivl));
  endtask

  task automatic test_idle_requests();
    send_req(REQ_TICK, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF);
    send_req(REQ_CANCEL, 32'h0000_0000, 16'h7FFF, 16'h8000);
    send_req(REQ_UNUSED, 32'hAAAA_5555, 16'hFFFF, 16'h0000);
    send_req(REQ_TICK, 32'h5555_AAAA, 16'h0000, 16'hFFFF);
  endtask

  task automatic test_start_and_cancel();
    send_req(REQ_START, 32'hFFFF_FFF0, 16'h8000, 16'h7FFF);
    send_req(REQ_START, 32'h0000_0000, 16'h1234, 16'h4321);
    send_req(REQ_UNUSED, 32'h0000_0008, 16'h0000, 16'h0000);
    // get-ready tick across the time wrap
    send_req(REQ_TICK, 32'h0000_0020, 16'h7FFF, 16'h8000);
    send_req(REQ_CANCEL, 32'h0000_0030, 16'h0000, 16'h0000);
    send_req(REQ_CANCEL, 32'h0000_0040, 16'h0000, 16'h0000);
  endtask

  task automatic test_timeout();
    send_req(REQ_START, 32'd1000, 16'd100, 16'hFF9C);
    send_req(REQ_TICK, 32'd4000, 16'd100, 16'hFF9C);
    send_req(REQ_TICK, 32'd11001, 16'd100, 16'hFF9C);
  endtask

  task automatic test_register_extremes();
    drain_results();
    set_config(65535, 1023, 65535, 65535, 65535, 1023);
    send_req(REQ_START, 32'h8000_0000, 16'h7FFF, 16'h8000);
    send_req(REQ_TICK, 32'h8000_FFFE, 16'h7FFF, 16'h8000);
    send_req(REQ_TICK, 32'h8001_0000, 16'h7FFF, 16'h8000);
    drain_results();
    set_config(0, 0, 0, 0, 0, 0);
    send_req(REQ_START, 32'h0F0F_0F0F, 16'h1111, 16'h2222);
    send_req(REQ_TICK, 32'h0F0F_0F0F, 16'h1111, 16'h2222);
    send_req(REQ_TICK, 32'h0F0F_0F10, 16'h1111, 16'h2222);
    // zero threshold: a one-count move fails the run
    drain_results();
    write_reg(CFG_TIMEOUT_MS, 16'hFFFF);
    send_req(REQ_START, 32'h7000_0000, 16'h1111, 16'h2222);
    send_req(REQ_TICK, 32'h7000_0005, 16'h1112, 16'h2222);
  endtask

  task automatic test_done_without_samples();
    logic [TIME_W-1:0] t;
    drain_results();
    set_config(512, 0, 0, 0, 65535, 1023);
    t = smp_t_last;
    send_req(REQ_START, t, 16'h0400, 16'hFC00);
    send_req(REQ_TICK, t + 1, 16'h0400, 16'hFC00);
  endtask

  task automatic test_count_saturation();
    logic [TIME_W-1:0] t;
    drain_results();
    set_config(65535, 1023, 0, 100, 65535, 0);
    t = $urandom;
    send_req(REQ_START, t, clamp_sample(int'($urandom_range(0, 32766)) - 16383),
             clamp_sample(int'($urandom_range(0, 32766)) - 16383));
    // frozen time keeps the run open while the count runs into its ceiling
    repeat (1030) begin
      send_req(REQ_TICK, t + 50, clamp_sample(int'($urandom_range(0, 32766)) - 16383),
               clamp_sample(int'($urandom_range(0, 32766)) - 16383));
    end
    send_req(REQ_TICK, t + 101, clamp_sample(int'($urandom_range(0, 32766)) - 16383),
             clamp_sample(int'($urandom_range(0, 32766)) - 16383));
  endtask

  task automatic test_random_runs(int unsigned target);
    int unsigned       roll;
    int unsigned       rdy;
    int unsigned       tot;
    int unsigned       tmo;
    int unsigned       thr;
    int unsigned       ticks;
    int unsigned       runs;
    int                amp;
    int                base_y;
    int                base_z;
    logic [TIME_W-1:0] t;
    runs = 0;
    while (items_sent < target) begin
      if (runs == 0 || $urandom_range(0, 3) == 0) begin
        drain_results();
        rdy = $urandom_range(0, 30);
        tot = rdy + $urandom_range(0, 120);
        tmo = ($urandom_range(0, 5) == 0) ? $urandom_range(0, tot)
                                           : tot + $urandom_range(0, 80);
        roll = $urandom_range(0, 9);
        thr = (roll == 0) ? 0 : (roll == 1) ? 65535 : $urandom_range(20, 3000);
        set_config(thr, $urandom_range(0, 15), rdy, tot, tmo, $urandom_range(0, 12));
      end
      runs++;
      quiet <= ($urandom_range(0, 4) == 0);
      t = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 200) : $urandom;
      base_y = int'($urandom_range(0, 65535)) + SMIN;
      base_z = int'($urandom_range(0, 65535)) + SMIN;
      // jitter per axis stays within a quarter of the threshold
      amp = (thr_c / 4 > 8000) ? 8000 : int'(thr_c / 4);
      if ($urandom_range(0, 9) == 0) send_req(REQ_TICK, t, 16'($urandom), 16'($urandom));
      send_req(REQ_START, t, clamp_sample(base_y), clamp_sample(base_z));
      ticks = 0;
      while (cal_active && ticks < 400) begin
        ticks++;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          send_req((roll == 0) ? REQ_UNUSED : REQ_START, t, 16'($urandom), 16'($urandom));
        end else if (roll < 4) begin
          send_req(REQ_CANCEL, t, 16'($urandom), 16'($urandom));
        end else if (roll < 5) begin
          t = t - 1 - $urandom_range(0, 50);
          send_req(REQ_TICK, t, clamp_sample(base_y), clamp_sample(base_z));
        end else if (roll < 6) begin
          t = t + tmo_c + 1 + $urandom_range(0, 1000);
          send_req(REQ_TICK, t, clamp_sample(base_y), clamp_sample(base_z));
        end else if (roll < 8) begin
          t = t + $urandom_range(0, 2 * ivl_c + 2);
          send_req(REQ_TICK, t, 16'($urandom), 16'($urandom));
        end else begin
          t = t + $urandom_range(0, 2 * ivl_c + 2);
          send_req(REQ_TICK, t,
                   clamp_sample(base_y + int'($urandom_range(0, 2 * amp)) - amp),
                   clamp_sample(base_z + int'($urandom_range(0, 2 * amp)) - amp));
        end
      end
    end
    quiet <= 1'b0;
  endtask

  always @(posedge clk) begin
    calib_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (calib_reports_q.size() == 0) begin
        report_mismatch("transaction with nothing pending", status, 0);
      end else begin
        want = calib_reports_q.pop_front();
        if (status != want.status) report_mismatch("status", status, want.status);
        if (origin_y != want.origin_y) report_mismatch("origin_y", origin_y, want.origin_y);
        if (origin_z != want.origin_z) report_mismatch("origin_z", origin_z, want.origin_z);
        if (samples_taken != want.samples) begin
          report_mismatch("samples_taken", samples_taken, want.samples);
        end
        if (elapsed_ms != want.elapsed) report_mismatch("elapsed_ms", elapsed_ms, want.elapsed);
      end
    end
  end

  // receiver back-pressure
  initial begin
    int unsigned n;
    forever begin
      n = quiet ? 30 : $urandom_range(1, 24);
      repeat (n) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
      if (!quiet) begin
        n = idle_len();
        repeat (n) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d reports still pending", calib_reports_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_requests();
    test_start_and_cancel();
    test_timeout();
    test_register_extremes();
    test_done_without_samples();
    test_count_saturation();
    test_random_runs(1750);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d transactions, %0d samples arrived with the count saturated",
             items_sent, n_saturated);
    $display("calibrations finished: %0d done, %0d moved, %0d timed out, %0d cancelled",
             n_done, n_moved, n_timeout, n_cancel);
    if (n_mismatch == 0 && calib_reports_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
